>>> sv/tlqe_pkg.sv
// Shared constants, types and helpers for the thick line quad expander.
package tlqe_pkg;

   localparam int FRAC_BITS_DEF = 16;
   localparam int CSR_W = 18;
   localparam int COORD_W = 32;
   localparam int LW_W = 31;
   localparam int COLOR_W = 32;
   localparam int DIFF_W = 33;
   localparam int CROSS_W = 53;
   localparam int MAG_W = 52;
   localparam int NRM_W = 30;
   localparam int SUM_W = 62;
   localparam int LEN_W = 31;
   localparam int PROD_W = 61;
   localparam int DIVD_W = 62;
   localparam int DIVS_W = 32;
   localparam int QUO_W = 32;
   localparam int OFF_W = 33;

   typedef enum logic [1:0] {
      CSR_CAM_X = 2'd0,
      CSR_CAM_Y = 2'd1,
      CSR_CAM_Z = 2'd2,
      CSR_NONE  = 2'd3
   } csr_idx_type;

   // Leading-one position of a nonzero magnitude; 0 when the value is zero.
   function automatic logic [5:0] msb_pos(input logic [MAG_W-1:0] v);
      logic [5:0] p;
      p = '0;
      for (int i = 0; i < MAG_W; i++) begin
         if (v[i]) p = 6'(i);
      end
      return p;
   endfunction

   // Clamp a 34-bit sum into the signed 32-bit range.
   function automatic logic [COORD_W-1:0] sat32(input logic signed [OFF_W:0] v);
      logic [COORD_W-1:0] r;
      if (v > 34'sh0_7FFF_FFFF) r = 32'h7FFF_FFFF;
      else if (v < -34'sh0_8000_0000) r = 32'h8000_0000;
      else r = v[COORD_W-1:0];
      return r;
   endfunction

endpackage

>>> sv/thick_line_quad_expander.sv
// Top level: expands thick line segments into camera-facing strip quads.
//
//   channel  ports   direction  beat
//   request  req_*   in         one segment: endpoints, width, color
//   response rsp_*   out        one vertex: corner, position, uv, color
//   csr      csr_*   in         one camera register write, no wait
//
// Flow: one segment enters per cycle while the pipe moves and yields four
// vertex beats, so the next segment waits on the single response port for the
// quad's last vertex. Accepting edge to rsp_valid: 7 front stages, 32 square
// root, 1 numerator, 33 in the three parallel divider lanes, 1 output register.
// Reset clears all valid bits and sets the camera vector to (0,0,-1).
// Stalls: the whole pipe freezes while the output stage still owes vertices.
module thick_line_quad_expander
   import tlqe_pkg::*;
#(
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [COORD_W-1:0]   req_start_x,
   input  logic [COORD_W-1:0]   req_start_y,
   input  logic [COORD_W-1:0]   req_start_z,
   input  logic [COORD_W-1:0]   req_end_x,
   input  logic [COORD_W-1:0]   req_end_y,
   input  logic [COORD_W-1:0]   req_end_z,
   input  logic [LW_W-1:0]      req_line_width,
   input  logic [COLOR_W-1:0]   req_rgba,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [1:0]           rsp_corner,
   output logic [COORD_W-1:0]   rsp_pos_x,
   output logic [COORD_W-1:0]   rsp_pos_y,
   output logic [COORD_W-1:0]   rsp_pos_z,
   output logic                 rsp_tex_u,
   output logic                 rsp_tex_v,
   output logic [COLOR_W-1:0]   rsp_vert_color,
   output logic                 rsp_last_corner,
   input  logic                 csr_we,
   input  logic [1:0]           csr_index,
   input  logic [CSR_W-1:0]     csr_wdata
);

   // Camera register reset value is -1.0 in the chosen fraction format.
   localparam logic [CSR_W-1:0] CAM_Z_RST = CSR_W'(-(64'sd1 <<< FRAC_BITS));

   // Payload carried alongside the offset computation.
   typedef struct packed {
      logic [COORD_W-1:0] sx, sy, sz, ex, ey, ez;
      logic [COLOR_W-1:0] color;
      logic [LW_W-1:0]    lw;
      logic [2:0]         neg;
      logic               zero;
   } carry_type;
   localparam int CW = $bits(carry_type);

   logic [CSR_W-1:0] cam_x_ff, cam_y_ff, cam_z_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cam_x_ff <= '0;
         cam_y_ff <= '0;
         cam_z_ff <= CAM_Z_RST;
      end else if (csr_we) begin
         unique case (csr_idx_type'(csr_index))
            CSR_CAM_X: cam_x_ff <= csr_wdata;
            CSR_CAM_Y: cam_y_ff <= csr_wdata;
            CSR_CAM_Z: cam_z_ff <= csr_wdata;
            CSR_NONE:  ;
            default:   ;
         endcase
      end
   end

   // Pipe moves unless the output stage is busy with an unfinished quad.
   logic       out_vld_ff;
   logic [1:0] corner_ff;
   logic       advance;
   assign advance   = !out_vld_ff || (rsp_ready && corner_ff == 2'd3);
   assign req_ready = advance;

   // Stage 1: capture and difference.
   logic                     s1_vld_ff;
   logic signed [DIFF_W-1:0] d_ff [3];
   carry_type                c1_ff;
   always_ff @(posedge clock) begin
      if (reset) s1_vld_ff <= 1'b0;
      else if (advance) s1_vld_ff <= req_valid;
   end
   always_ff @(posedge clock) begin
      if (advance) begin
         d_ff[0] <= DIFF_W'($signed(req_end_x)) - DIFF_W'($signed(req_start_x));
         d_ff[1] <= DIFF_W'($signed(req_end_y)) - DIFF_W'($signed(req_start_y));
         d_ff[2] <= DIFF_W'($signed(req_end_z)) - DIFF_W'($signed(req_start_z));
         c1_ff <= '{sx: req_start_x, sy: req_start_y, sz: req_start_z,
                    ex: req_end_x, ey: req_end_y, ez: req_end_z,
                    color: req_rgba, lw: req_line_width, neg: '0, zero: 1'b0};
      end
   end

   // Stage 2: six products.
   logic                      s2_vld_ff;
   logic signed [CROSS_W-1:0] p_ff [6];
   carry_type                 c2_ff;
   logic signed [CSR_W-1:0]   cx, cy, cz;
   assign cx = $signed(cam_x_ff);
   assign cy = $signed(cam_y_ff);
   assign cz = $signed(cam_z_ff);
   always_ff @(posedge clock) begin
      if (reset) s2_vld_ff <= 1'b0;
      else if (advance) s2_vld_ff <= s1_vld_ff;
   end
   always_ff @(posedge clock) begin
      if (advance) begin
         p_ff[0] <= CROSS_W'(d_ff[1] * cz);
         p_ff[1] <= CROSS_W'(d_ff[2] * cy);
         p_ff[2] <= CROSS_W'(d_ff[2] * cx);
         p_ff[3] <= CROSS_W'(d_ff[0] * cz);
         p_ff[4] <= CROSS_W'(d_ff[0] * cy);
         p_ff[5] <= CROSS_W'(d_ff[1] * cx);
         c2_ff <= c1_ff;
      end
   end

   // Stage 3: cross product components to sign and magnitude.
   logic                      s3_vld_ff;
   logic [MAG_W-1:0]          m_ff [3];
   carry_type                 c3_ff;
   carry_type                 c3_in;
   logic signed [CROSS_W-1:0] w [3];
   assign w[0] = p_ff[0] - p_ff[1];
   assign w[1] = p_ff[2] - p_ff[3];
   assign w[2] = p_ff[4] - p_ff[5];
   always_comb begin
      c3_in = c2_ff;
      for (int i = 0; i < 3; i++) c3_in.neg[i] = w[i][CROSS_W-1];
   end
   always_ff @(posedge clock) begin
      if (reset) s3_vld_ff <= 1'b0;
      else if (advance) s3_vld_ff <= s2_vld_ff;
   end
   always_ff @(posedge clock) begin
      if (advance) begin
         c3_ff <= c3_in;
         for (int i = 0; i < 3; i++) begin
            m_ff[i] <= w[i][CROSS_W-1] ? MAG_W'(-w[i]) : MAG_W'(w[i]);
         end
      end
   end

   // Stage 4: find leading one of the largest magnitude.
   logic             s4_vld_ff;
   logic [MAG_W-1:0] m4_ff [3];
   logic [5:0]       top_ff;
   carry_type        c4_ff;
   carry_type        c4_in;
   always_comb begin
      c4_in      = c3_ff;
      c4_in.zero = (m_ff[0] | m_ff[1] | m_ff[2]) == '0;
   end
   always_ff @(posedge clock) begin
      if (reset) s4_vld_ff <= 1'b0;
      else if (advance) s4_vld_ff <= s3_vld_ff;
   end
   always_ff @(posedge clock) begin
      if (advance) begin
         m4_ff  <= m_ff;
         top_ff <= msb_pos(m_ff[0] | m_ff[1] | m_ff[2]);
         c4_ff  <= c4_in;
      end
   end

   // Stage 5: scale so the largest lies in [2^29, 2^30).
   logic             s5_vld_ff;
   logic [NRM_W-1:0] n_ff [3];
   carry_type        c5_ff;
   always_ff @(posedge clock) begin
      if (reset) s5_vld_ff <= 1'b0;
      else if (advance) s5_vld_ff <= s4_vld_ff;
   end
   always_ff @(posedge clock) begin
      if (advance) begin
         c5_ff <= c4_ff;
         for (int i = 0; i < 3; i++) begin
            if (top_ff >= 6'd29)
               n_ff[i] <= NRM_W'(m4_ff[i] >> (top_ff - 6'd29));
            else
               n_ff[i] <= NRM_W'(m4_ff[i] << (6'd29 - top_ff));
         end
      end
   end

   // Stage 6: squares.
   logic                 s6_vld_ff;
   logic [2*NRM_W-1:0]   sq_ff [3];
   logic [NRM_W-1:0]     n6_ff [3];
   carry_type            c6_ff;
   always_ff @(posedge clock) begin
      if (reset) s6_vld_ff <= 1'b0;
      else if (advance) s6_vld_ff <= s5_vld_ff;
   end
   always_ff @(posedge clock) begin
      if (advance) begin
         for (int i = 0; i < 3; i++) sq_ff[i] <= n_ff[i] * n_ff[i];
         n6_ff <= n_ff;
         c6_ff <= c5_ff;
      end
   end

   // Stage 7: sum of squares, then the square root pipe.
   logic [SUM_W-1:0] sum_ff;
   logic [NRM_W-1:0] n7_ff [3];
   carry_type        c7_ff;
   logic             s7_vld_ff;
   always_ff @(posedge clock) begin
      if (reset) s7_vld_ff <= 1'b0;
      else if (advance) s7_vld_ff <= s6_vld_ff;
   end
   always_ff @(posedge clock) begin
      if (advance) begin
         sum_ff <= SUM_W'(sq_ff[0]) + SUM_W'(sq_ff[1]) + SUM_W'(sq_ff[2]);
         n7_ff  <= n6_ff;
         c7_ff  <= c6_ff;
      end
   end

   localparam int SQ_TAG = CW + 3*NRM_W;
   logic              sq_vld;
   logic [LEN_W-1:0]  len;
   logic [SQ_TAG-1:0] sq_tag;
   tlqe_sqrt #(.TAG_W(SQ_TAG)) u_sqrt (
      .clock, .reset, .advance,
      .in_valid(s7_vld_ff), .in_radicand(sum_ff),
      .in_tag({c7_ff, n7_ff[0], n7_ff[1], n7_ff[2]}),
      .out_valid(sq_vld), .out_root(len), .out_tag(sq_tag)
   );

   carry_type        c8;
   logic [NRM_W-1:0] n8 [3];
   assign {c8, n8[0], n8[1], n8[2]} = sq_tag;

   // Stage 8: numerators m*lw + len; zero lines take len=1 so they divide to 0.
   logic             s8_vld_ff;
   logic [DIVD_W-1:0] num_ff [3];
   logic [DIVS_W-1:0] den_ff;
   carry_type         c9_ff;
   logic [LEN_W-1:0]  len_use;
   assign len_use = c8.zero ? LEN_W'(1) : len;
   always_ff @(posedge clock) begin
      if (reset) s8_vld_ff <= 1'b0;
      else if (advance) s8_vld_ff <= sq_vld;
   end
   always_ff @(posedge clock) begin
      if (advance) begin
         for (int i = 0; i < 3; i++)
            num_ff[i] <= DIVD_W'(n8[i] * c8.lw) + DIVD_W'(len_use);
         den_ff <= {len_use, 1'b0};
         c9_ff  <= c8;
      end
   end

   // Three parallel divider lanes; lane 0 carries the payload.
   logic             dv_vld [3];
   logic [QUO_W-1:0] q [3];
   logic [CW-1:0]    dtag [3];
   for (genvar l = 0; l < 3; l++) begin : g_div
      tlqe_div #(.TAG_W(CW)) u_div (
         .clock, .reset, .advance,
         .in_valid(s8_vld_ff), .in_dividend(num_ff[l]), .in_divisor(den_ff),
         .in_tag(c9_ff),
         .out_valid(dv_vld[l]), .out_quo(q[l]), .out_tag(dtag[l])
      );
   end
   carry_type cd;
   assign cd = carry_type'(dtag[0] | dtag[1] & '0 | dtag[2] & '0);

   // Stage 9: signed offsets, then the output register that walks corners.
   logic signed [OFF_W-1:0] off [3];
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         off[i] = cd.zero ? '0 :
                  (cd.neg[i] ? -$signed(OFF_W'(q[i])) : $signed(OFF_W'(q[i])));
      end
   end

   logic signed [OFF_W-1:0] off_ff [3];
   carry_type               co_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
         corner_ff  <= '0;
      end else if (advance) begin
         out_vld_ff <= dv_vld[0] & dv_vld[1] & dv_vld[2];
         corner_ff  <= '0;
      end else if (rsp_ready) begin
         corner_ff <= corner_ff + 2'd1;
      end
   end
   always_ff @(posedge clock) begin
      if (advance) begin
         off_ff <= off;
         co_ff  <= cd;
      end
   end

   logic                     plus, at_end;
   logic signed [OFF_W:0]    bx, by, bz;
   assign plus   = corner_ff[0];
   assign at_end = !corner_ff[1];
   assign bx = (OFF_W+1)'($signed(at_end ? co_ff.ex : co_ff.sx));
   assign by = (OFF_W+1)'($signed(at_end ? co_ff.ey : co_ff.sy));
   assign bz = (OFF_W+1)'($signed(at_end ? co_ff.ez : co_ff.sz));

   assign rsp_valid       = out_vld_ff;
   assign rsp_corner      = corner_ff;
   assign rsp_pos_x = sat32(plus ? bx + (OFF_W+1)'(off_ff[0]) : bx - (OFF_W+1)'(off_ff[0]));
   assign rsp_pos_y = sat32(plus ? by + (OFF_W+1)'(off_ff[1]) : by - (OFF_W+1)'(off_ff[1]));
   assign rsp_pos_z = sat32(plus ? bz + (OFF_W+1)'(off_ff[2]) : bz - (OFF_W+1)'(off_ff[2]));
   assign rsp_tex_u       = at_end;
   assign rsp_tex_v       = plus;
   assign rsp_vert_color  = co_ff.color;
   assign rsp_last_corner = corner_ff == 2'd3;

endmodule

>>> sv/tlqe_sqrt.sv
// Pipelined integer square root, one result bit per stage.
module tlqe_sqrt
   import tlqe_pkg::*;
#(
   parameter int TAG_W = 8
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 advance,
   input  logic                 in_valid,
   input  logic [SUM_W-1:0]     in_radicand,
   input  logic [TAG_W-1:0]     in_tag,
   output logic                 out_valid,
   output logic [LEN_W-1:0]     out_root,
   output logic [TAG_W-1:0]     out_tag
);

   // Stage i settles root bit LEN_W-1-i.
   logic [LEN_W:0]            vld_ff;
   logic [SUM_W+1:0]          rem_ff  [LEN_W+1];
   logic [LEN_W-1:0]          root_ff [LEN_W+1];
   logic [TAG_W-1:0]          tag_ff  [LEN_W+1];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (advance) begin
         vld_ff <= {vld_ff[LEN_W-1:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rem_ff[0]  <= {2'b00, in_radicand};
         root_ff[0] <= '0;
         tag_ff[0]  <= in_tag;
      end
   end

   for (genvar g = 0; g < LEN_W; g++) begin : g_stage
      localparam int B = LEN_W - 1 - g;
      logic [SUM_W+1:0] trial;
      logic [SUM_W+1:0] cur;
      // (R + 2^B)^2 - R^2 = R*2^(B+1) + 2^(2B); R has no bits below B+1.
      always_comb begin
         cur   = ((SUM_W+2)'(root_ff[g]) << (B+1)) | ((SUM_W+2)'(1) << (2*B));
         trial = {(SUM_W+2){1'b0}};
         trial = cur;
      end
      always_ff @(posedge clock) begin
         if (advance) begin
            tag_ff[g+1] <= tag_ff[g];
            if (rem_ff[g] >= trial) begin
               rem_ff[g+1]  <= rem_ff[g] - trial;
               root_ff[g+1] <= root_ff[g] | (LEN_W'(1) << B);
            end else begin
               rem_ff[g+1]  <= rem_ff[g];
               root_ff[g+1] <= root_ff[g];
            end
         end
      end
   end

   assign out_valid = vld_ff[LEN_W];
   assign out_root  = root_ff[LEN_W];
   assign out_tag   = tag_ff[LEN_W];

endmodule

>>> sv/tlqe_div.sv
// Pipelined restoring divider, one quotient bit per stage.
module tlqe_div
   import tlqe_pkg::*;
#(
   parameter int TAG_W = 8
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 advance,
   input  logic                 in_valid,
   input  logic [DIVD_W-1:0]    in_dividend,
   input  logic [DIVS_W-1:0]    in_divisor,
   input  logic [TAG_W-1:0]     in_tag,
   output logic                 out_valid,
   output logic [QUO_W-1:0]     out_quo,
   output logic [TAG_W-1:0]     out_tag
);

   // Quotient fits QUO_W bits: |m| < 2^30 so q <= lw*2^29/len < 2^31.
   logic [QUO_W:0]          vld_ff;
   logic [DIVD_W-1:0]       rem_ff [QUO_W+1];
   logic [DIVS_W-1:0]       dvs_ff [QUO_W+1];
   logic [QUO_W-1:0]        quo_ff [QUO_W+1];
   logic [TAG_W-1:0]        tag_ff [QUO_W+1];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (advance) begin
         vld_ff <= {vld_ff[QUO_W-1:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rem_ff[0] <= in_dividend;
         dvs_ff[0] <= in_divisor;
         quo_ff[0] <= '0;
         tag_ff[0] <= in_tag;
      end
   end

   for (genvar g = 0; g < QUO_W; g++) begin : g_stage
      localparam int B = QUO_W - 1 - g;
      logic [DIVD_W+QUO_W-1:0] shd;
      assign shd = (DIVD_W+QUO_W)'(dvs_ff[g]) << B;
      always_ff @(posedge clock) begin
         if (advance) begin
            dvs_ff[g+1] <= dvs_ff[g];
            tag_ff[g+1] <= tag_ff[g];
            if ((DIVD_W+QUO_W)'(rem_ff[g]) >= shd) begin
               rem_ff[g+1] <= rem_ff[g] - shd[DIVD_W-1:0];
               quo_ff[g+1] <= quo_ff[g] | (QUO_W'(1) << B);
            end else begin
               rem_ff[g+1] <= rem_ff[g];
               quo_ff[g+1] <= quo_ff[g];
            end
         end
      end
   end

   assign out_valid = vld_ff[QUO_W];
   assign out_quo   = quo_ff[QUO_W];
   assign out_tag   = tag_ff[QUO_W];

endmodule
